// ===== sv/mts_pkg.sv =====
// ----------------------------------------------------------------------------
// mts_pkg
// Shared constants and types for the max tracking stack: sizes, error codes,
// operation codes and the controller to datapath command bundle.
// ----------------------------------------------------------------------------
package mts_pkg;

	// stack geometry
	localparam int DEPTH   = 1024;
	localparam int AW      = $clog2(DEPTH);
	localparam int CW      = $clog2(DEPTH + 1);
	localparam int DATA_W  = 32;
	localparam int DEPTH_W = 11;
	localparam int ERR_W   = 2;

	// operation codes
	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	// error codes
	localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
	localparam logic [ERR_W-1:0] ERR_POP_EMPTY = 2'd1;
	localparam logic [ERR_W-1:0] ERR_PUSH_FULL = 2'd2;

	// commands from the controller to the datapath
	typedef struct packed {
		logic capture;  // latch the accepted item
		logic exec;     // apply push or pop, start top refill reads
		logic load;     // take refilled tops from the memories
		logic emit;     // load the output register
	} dp_cmd_t;

endpackage

// ===== sv/mts_dp.sv =====
// ----------------------------------------------------------------------------
// mts_dp
// Datapath of the max tracking stack: value and maxima memories, counts,
// registered copies of both stack tops and the output register.
// ----------------------------------------------------------------------------
module mts_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  mts_pkg::dp_cmd_t                       cmd,
	input  logic                                   kind,
	input  logic signed [mts_pkg::DATA_W-1:0]      value,
	output logic signed [mts_pkg::DATA_W-1:0]      current_max,
	output logic                                   stack_empty,
	output logic        [mts_pkg::DEPTH_W-1:0]     depth,
	output logic        [mts_pkg::ERR_W-1:0]       error
);

	logic [mts_pkg::DATA_W-1:0] vmem [mts_pkg::DEPTH];
	logic [mts_pkg::DATA_W-1:0] mmem [mts_pkg::DEPTH];

	logic                              kind_q;
	logic signed [mts_pkg::DATA_W-1:0] value_q;
	logic [mts_pkg::CW-1:0]            vcnt_q;
	logic [mts_pkg::CW-1:0]            mcnt_q;
	logic [mts_pkg::DATA_W-1:0]        vtop_q;
	logic [mts_pkg::DATA_W-1:0]        mtop_q;
	logic [mts_pkg::DATA_W-1:0]        vrd_q;
	logic [mts_pkg::DATA_W-1:0]        mrd_q;
	logic                              reload_q;
	logic [mts_pkg::ERR_W-1:0]         err_q;

	logic signed [mts_pkg::DATA_W-1:0] cur_max_q;
	logic                              empty_q;
	logic [mts_pkg::DEPTH_W-1:0]       depth_q;
	logic [mts_pkg::ERR_W-1:0]         err_out_q;

	logic                   full;
	logic                   vempty;
	logic                   push_ok;
	logic                   pop_ok;
	logic                   max_push;
	logic                   max_pop;
	logic [mts_pkg::AW-1:0] vrd_addr;
	logic [mts_pkg::AW-1:0] mrd_addr;
	logic [mts_pkg::ERR_W-1:0] err_d;

	// capture the accepted item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= kind;
			value_q <= value;
		end
	end

	// operation decode against the current tops
	always_comb begin
		full     = (vcnt_q == mts_pkg::CW'(mts_pkg::DEPTH));
		vempty   = (vcnt_q == '0);
		push_ok  = (kind_q == mts_pkg::KIND_PUSH) && !full;
		pop_ok   = (kind_q == mts_pkg::KIND_POP) && !vempty;
		max_push = push_ok && ((mcnt_q == '0) || ($signed(mtop_q) <= value_q));
		max_pop  = pop_ok && (mcnt_q != '0) && (mtop_q == vtop_q);
		// addresses of the new tops after a pop
		vrd_addr = mts_pkg::AW'(vcnt_q - mts_pkg::CW'(2));
		mrd_addr = max_pop ? mts_pkg::AW'(mcnt_q - mts_pkg::CW'(2))
		                   : mts_pkg::AW'(mcnt_q - mts_pkg::CW'(1));
		if ((kind_q == mts_pkg::KIND_PUSH) && full) begin
			err_d = mts_pkg::ERR_PUSH_FULL;
		end else if ((kind_q == mts_pkg::KIND_POP) && vempty) begin
			err_d = mts_pkg::ERR_POP_EMPTY;
		end else begin
			err_d = mts_pkg::ERR_OK;
		end
	end

	// value memory: write on push, read the next top on pop
	always_ff @(posedge clk) begin
		if (cmd.exec && push_ok) begin
			vmem[vcnt_q[mts_pkg::AW-1:0]] <= value_q;
		end else if (cmd.exec && pop_ok) begin
			vrd_q <= vmem[vrd_addr];
		end
	end

	// maxima memory: write on qualifying push, read the next top on pop
	always_ff @(posedge clk) begin
		if (cmd.exec && max_push) begin
			mmem[mcnt_q[mts_pkg::AW-1:0]] <= value_q;
		end else if (cmd.exec && pop_ok) begin
			mrd_q <= mmem[mrd_addr];
		end
	end

	// counts and refill flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q   <= '0;
			mcnt_q   <= '0;
			reload_q <= 1'b0;
		end else if (cmd.exec) begin
			reload_q <= pop_ok;
			if (push_ok) begin
				vcnt_q <= vcnt_q + mts_pkg::CW'(1);
			end else if (pop_ok) begin
				vcnt_q <= vcnt_q - mts_pkg::CW'(1);
			end
			if (max_push) begin
				mcnt_q <= mcnt_q + mts_pkg::CW'(1);
			end else if (max_pop) begin
				mcnt_q <= mcnt_q - mts_pkg::CW'(1);
			end
		end
	end

	// registered tops and error of the item in flight
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			err_q <= err_d;
			if (push_ok) begin
				vtop_q <= value_q;
			end
			if (max_push) begin
				mtop_q <= value_q;
			end
		end else if (cmd.load && reload_q) begin
			vtop_q <= vrd_q;
			mtop_q <= mrd_q;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			cur_max_q <= (mcnt_q != '0) ? $signed(mtop_q) : '0;
			empty_q   <= (vcnt_q == '0);
			depth_q   <= mts_pkg::DEPTH_W'(vcnt_q);
			err_out_q <= err_q;
		end
	end

	assign current_max = cur_max_q;
	assign stack_empty = empty_q;
	assign depth       = depth_q;
	assign error       = err_out_q;

endmodule

// ===== sv/mts_ctrl.sv =====
// ----------------------------------------------------------------------------
// mts_ctrl
// Controller of the max tracking stack: sequences each item through execute,
// top refill and output, and owns both channel handshakes.
// ----------------------------------------------------------------------------
module mts_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	output mts_pkg::dp_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_LOAD = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;
	logic       in_acc;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		cmd.load    = 1'b0;
		cmd.emit    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				// wait here until the output register can take the result
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/max_tracking_stack.sv =====
// ----------------------------------------------------------------------------
// max_tracking_stack
// LIFO of signed 32-bit values that reports its current maximum after every
// push or pop, using an auxiliary stack of running maxima.
// ----------------------------------------------------------------------------
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------
//   in      | input     | in_valid / in_stall | kind, value
//   out     | output    | out_valid/out_stall | current_max, stack_empty,
//           |           |                     | depth, error
//
// Each item passes through capture, execute with the memory read of the
// new tops after a pop, top reload and output register load. The result is
// offered from the output register, after which the next item can be taken.
// One item is in flight at a time; a new item is accepted once the result
// of the previous one sits in the output register, even while it waits.
// Output stall holds the result and, for the next item, the final step.
// Reset clears the counts and handshake state; memory contents need no clear.
// ----------------------------------------------------------------------------
module max_tracking_stack (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   kind,
	input  logic signed [mts_pkg::DATA_W-1:0]      value,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [mts_pkg::DATA_W-1:0]      current_max,
	output logic                                   stack_empty,
	output logic        [mts_pkg::DEPTH_W-1:0]     depth,
	output logic        [mts_pkg::ERR_W-1:0]       error
);

	mts_pkg::dp_cmd_t cmd;

	// sequencing and handshakes
	mts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// stacks, tops and result
	mts_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.kind        (kind),
		.value       (value),
		.current_max (current_max),
		.stack_empty (stack_empty),
		.depth       (depth),
		.error       (error)
	);

endmodule

// ===== sv/mts_checker.sv =====
// ----------------------------------------------------------------------------
// mts_checker
// Port-level checks of the max tracking stack, bound to the top level.
// ----------------------------------------------------------------------------
module mts_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   out_valid,
	input logic                                   out_stall,
	input logic signed [mts_pkg::DATA_W-1:0]      current_max,
	input logic                                   stack_empty,
	input logic        [mts_pkg::DEPTH_W-1:0]     depth,
	input logic        [mts_pkg::ERR_W-1:0]       error
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	// a stalled result does not change
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable({current_max, stack_empty, depth, error}))
		else $error("result changed while stalled");

	// empty flag agrees with depth
	a_empty_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (stack_empty == (depth == '0)))
		else $error("stack_empty disagrees with depth");

	// an empty stack reports zero maximum
	a_empty_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stack_empty |-> (current_max == '0))
		else $error("nonzero maximum on empty stack");

	// an ignored pop leaves the stack empty
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (error == mts_pkg::ERR_POP_EMPTY) |-> stack_empty)
		else $error("pop-on-empty error with a non-empty stack");

endmodule

bind max_tracking_stack mts_checker u_mts_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.current_max (current_max),
	.stack_empty (stack_empty),
	.depth       (depth),
	.error       (error)
);
